>>> design/memory_pressure_level_monitor_top_defines.svh
// Assertion macros for the memory pressure level monitor checker.
// Each macro expects clk and rst in the scope where it is used.
`ifndef MEMORY_PRESSURE_LEVEL_MONITOR_TOP_DEFINES_SVH
`define MEMORY_PRESSURE_LEVEL_MONITOR_TOP_DEFINES_SVH

// same-cycle implication
`define MPLM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MPLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mplm_pkg.sv
// Shared widths, register indexes and reset values of the memory pressure level monitor.
// No dependencies.
package mplm_pkg;

  localparam int WM_W       = 48;
  localparam int TICK_W     = 32;
  localparam int LEVEL_W    = 3;
  localparam int EVL_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int NUM_WATERMARKS_DEF = 4;
  localparam int NUM_WM_REGS_MAX    = 4;

  localparam logic [WM_W-1:0]  WM_MAX          = {WM_W{1'b1}};
  localparam logic [EVL_W-1:0] MAX_EVICT_RESET = 3'd2;

  localparam logic [CFG_IDX_W-1:0] REG_WM_OOM      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WM_IMMINENT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WM_CRITICAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WM_WARNING  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HYSTERESIS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_EVICT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CONT_MODE   = 3'd7;

endpackage

>>> design/mplm_sample_if.sv
// Sample channel: valid/ready handshake carrying one free-memory sample word.
// Depends on mplm_pkg.
interface mplm_sample_if;
  import mplm_pkg::*;

  logic              valid;
  logic              ready;
  logic [WM_W-1:0]   free_bytes;
  logic [TICK_W-1:0] now_ticks;
  logic              alloc_failed;

  modport source (output valid, free_bytes, now_ticks, alloc_failed, input ready);
  modport sink   (input valid, free_bytes, now_ticks, alloc_failed, output ready);
endinterface

>>> design/mplm_result_if.sv
// Result channel: valid/ready handshake carrying one pressure report word.
// Depends on mplm_pkg.
interface mplm_result_if;
  import mplm_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic               signal;
  logic               evict_request;
  logic [WM_W-1:0]    evict_min_bytes;
  logic               stop_continuous;
  logic               oom_flag;

  modport source (output valid, level, signal, evict_request, evict_min_bytes,
                  stop_continuous, oom_flag, input ready);
  modport sink   (input valid, level, signal, evict_request, evict_min_bytes,
                  stop_continuous, oom_flag, output ready);
endinterface

>>> design/memory_pressure_level_monitor_top.sv
// Memory pressure level monitor: watermark banding, signal decision and eviction sizing.
// Depends on mplm_pkg, mplm_sample_if and mplm_result_if.
//
//   channel   direction  word
//   sample    in         free_bytes, now_ticks, alloc_failed
//   report    out        level, signal, evict_request, evict_min_bytes,
//                        stop_continuous, oom_flag
//   cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One word is accepted per cycle unless a stalled report holds a full input register;
// it goes through the input register and one evaluation stage into the result register.
// A stalled report holds the result register; only an empty input register takes a word.
// Synchronous active-high rst clears the levels to normal, the tick stamp and all
// configuration registers (max_evict_level to 2).
module memory_pressure_level_monitor_top #(
  parameter int NUM_WATERMARKS = mplm_pkg::NUM_WATERMARKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  mplm_sample_if.sink                      sample,
  mplm_result_if.source                    report,
  input  logic                             cfg_we,
  input  logic [mplm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mplm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mplm_pkg::*;

  localparam int LVL_W       = $clog2(NUM_WATERMARKS + 1);
  localparam int WM_IDX_W    = $clog2(NUM_WATERMARKS);
  localparam int NUM_WM_REGS = (NUM_WATERMARKS < NUM_WM_REGS_MAX) ? NUM_WATERMARKS
                                                                   : NUM_WM_REGS_MAX;
  localparam int WR_IDX_W    = $clog2(NUM_WM_REGS);
  localparam int CMP_W       = (LVL_W > EVL_W) ? LVL_W : EVL_W;
  localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(NUM_WATERMARKS);

  // configuration
  logic [WM_W-1:0]   wm_reg [NUM_WM_REGS];
  logic [WM_W-1:0]   debounce;
  logic [TICK_W-1:0] hysteresis;
  logic [EVL_W-1:0]  max_evict;
  logic              cont_mode;

  // running state
  logic [LVL_W-1:0]  cur_level;
  logic [LVL_W-1:0]  sig_level;
  logic [TICK_W-1:0] last_time;

  // input register
  logic              s_valid;
  logic [WM_W-1:0]   s_free;
  logic [TICK_W-1:0] s_now;
  logic              s_failed;

  // result register
  logic               o_valid;
  logic [LEVEL_W-1:0] o_level;
  logic               o_signal;
  logic               o_evict;
  logic [WM_W-1:0]    o_min_bytes;
  logic               o_stop;
  logic               o_oom;

  logic adv;

  logic [WM_W-1:0]     wm_eff [NUM_WATERMARKS];
  logic [LVL_W-1:0]    lo_lvl;
  logic [WM_IDX_W-1:0] lo_idx;
  logic [WM_IDX_W-1:0] up_idx;
  logic [WM_W-1:0]     lo_wm;
  logic [WM_W-1:0]     lower;
  logic [WM_W:0]       upper;
  logic                in_band;
  logic [LVL_W-1:0]    cnt;
  logic [LVL_W-1:0]    level_next;
  logic [TICK_W-1:0]   elapsed;
  logic                worse;
  logic                sig;
  logic [CMP_W-1:0]    lvl_c;
  logic [CMP_W-1:0]    mel_c;
  logic                evict;
  logic                stop;
  logic [WM_IDX_W-1:0] t_idx;
  logic [WM_W:0]       target;
  logic [WM_W:0]       shortfall;
  logic [WM_W-1:0]     min_bytes;

  for (genvar i = 0; i < NUM_WATERMARKS; i++) begin : g_wm
    if (i < NUM_WM_REGS) begin : g_reg
      assign wm_eff[i] = wm_reg[i];
    end else begin : g_fixed
      assign wm_eff[i] = WM_MAX;
    end
  end

  assign adv          = s_valid && (!o_valid || report.ready);
  assign sample.ready = !s_valid || adv;

  // band of the current level, widened by debounce
  always_comb begin
    lo_lvl  = cur_level - 1'b1;
    lo_idx  = (cur_level != '0) ? lo_lvl[WM_IDX_W-1:0] : '0;
    up_idx  = (cur_level < LVL_TOP) ? cur_level[WM_IDX_W-1:0] : '0;
    lo_wm   = wm_eff[lo_idx];
    lower   = (lo_wm > debounce) ? lo_wm - debounce : '0;
    upper   = {1'b0, wm_eff[up_idx]} + {1'b0, debounce};
    in_band = ((cur_level == '0) || (s_free >= lower)) &&
              ((cur_level == LVL_TOP) || ({1'b0, s_free} <= upper));
  end

  // first watermark not below the sample
  always_comb begin
    cnt = LVL_TOP;
    for (int i = NUM_WATERMARKS - 1; i >= 0; i--) begin
      if (!(s_free > wm_eff[i])) cnt = LVL_W'(i);
    end
  end

  always_comb begin
    priority if (s_failed) level_next = '0;
    else if (in_band)      level_next = cur_level;
    else                   level_next = cnt;

    elapsed = s_now - last_time;
    worse   = level_next < sig_level;
    sig     = worse || (elapsed >= hysteresis);
    lvl_c   = CMP_W'(level_next);
    mel_c   = CMP_W'(max_evict);
    evict   = worse && (lvl_c <= mel_c) && (level_next != '0);
    stop    = sig && !evict && cont_mode && (lvl_c > mel_c);

    t_idx     = (mel_c > CMP_W'(NUM_WATERMARKS - 1)) ? WM_IDX_W'(NUM_WATERMARKS - 1)
                                                      : mel_c[WM_IDX_W-1:0];
    target    = {1'b0, wm_eff[t_idx]} + {1'b0, debounce};
    shortfall = target - {1'b0, s_free};
    min_bytes = (evict && ({1'b0, s_free} < target)) ? shortfall[WM_W:1] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WM_REGS; i++) wm_reg[i] <= '0;
      debounce   <= '0;
      hysteresis <= '0;
      max_evict  <= MAX_EVICT_RESET;
      cont_mode  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WM_OOM, REG_WM_IMMINENT, REG_WM_CRITICAL, REG_WM_WARNING: begin
          if (cfg_index < CFG_IDX_W'(NUM_WM_REGS)) begin
            wm_reg[cfg_index[WR_IDX_W-1:0]] <= cfg_data[WM_W-1:0];
          end
        end
        REG_DEBOUNCE:   debounce   <= cfg_data[WM_W-1:0];
        REG_HYSTERESIS: hysteresis <= cfg_data[TICK_W-1:0];
        REG_MAX_EVICT:  max_evict  <= cfg_data[EVL_W-1:0];
        REG_CONT_MODE:  cont_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (sample.ready) begin
      s_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      s_free   <= sample.free_bytes;
      s_now    <= sample.now_ticks;
      s_failed <= sample.alloc_failed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level <= LVL_TOP;
      sig_level <= LVL_TOP;
      last_time <= '0;
      o_valid   <= 1'b0;
    end else begin
      if (adv) begin
        cur_level <= level_next;
        last_time <= s_now;
        if (sig) sig_level <= level_next;
        o_valid <= 1'b1;
      end else if (report.ready) begin
        o_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_level     <= LEVEL_W'(level_next);
      o_signal    <= sig;
      o_evict     <= evict;
      o_min_bytes <= min_bytes;
      o_stop      <= stop;
      o_oom       <= sig && (level_next == '0);
    end
  end

  assign report.valid           = o_valid;
  assign report.level           = o_level;
  assign report.signal          = o_signal;
  assign report.evict_request   = o_evict;
  assign report.evict_min_bytes = o_min_bytes;
  assign report.stop_continuous = o_stop;
  assign report.oom_flag        = o_oom;

endmodule

>>> design/mplm_checker.sv
// Port-level checks of the memory pressure level monitor, bound to its top level.
// Depends on mplm_pkg and memory_pressure_level_monitor_top_defines.svh.
`include "memory_pressure_level_monitor_top_defines.svh"

module mplm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mplm_pkg::LEVEL_W-1:0]   level,
  input logic                           signal,
  input logic                           evict_request,
  input logic [mplm_pkg::WM_W-1:0]      evict_min_bytes,
  input logic                           stop_continuous,
  input logic                           oom_flag
);
  import mplm_pkg::*;

  `MPLM_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(level) && $stable(evict_min_bytes) && $stable(signal), "stalled report word changed")
  `MPLM_ASSERT_NOW(a_oom, out_valid && oom_flag, signal && (level == '0) && !evict_request, "out-of-memory flag without signalled level 0")
  `MPLM_ASSERT_NOW(a_evict, out_valid && evict_request, signal && (level != '0) && !stop_continuous, "eviction request outside a worsening signal")
  `MPLM_ASSERT_NOW(a_min, out_valid && !evict_request, evict_min_bytes == '0, "eviction size without request")

endmodule

bind memory_pressure_level_monitor_top mplm_checker u_mplm_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (report.valid),
  .out_ready       (report.ready),
  .level           (report.level),
  .signal          (report.signal),
  .evict_request   (report.evict_request),
  .evict_min_bytes (report.evict_min_bytes),
  .stop_continuous (report.stop_continuous),
  .oom_flag        (report.oom_flag)
);
